/* design/sppq_pkg.sv */
// ----------------------------------------------------------------------------
// sppq_pkg
// Shared types and codes of the semaphore priority wait queue unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sppq_pkg;

    // operation codes
    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_CHG  = 2'd2;
    localparam logic [1:0] FUNC_REM  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] sem_id;
        logic [7:0] task_id;
        logic [7:0] priority_req;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_task;
        logic [7:0] out_prio;
        logic [2:0] queue_count;
    } t_out;

    typedef struct packed {
        logic [7:0] task_id;
        logic [7:0] prio;
    } t_entry;

    typedef enum logic [2:0] {
        IDX_HOLD = 3'd0,
        IDX_INC  = 3'd1,
        IDX_DEC  = 3'd2,
        IDX_ZERO = 3'd3,
        IDX_TAIL = 3'd4
    } t_idx_op;

    typedef enum logic [1:0] {
        OFF_ZERO  = 2'd0,
        OFF_PLUS  = 2'd1,
        OFF_MINUS = 2'd2
    } t_off;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       start;
        t_idx_op    idx_op;
        logic       rd_en;
        t_off       rd_off;
        logic       wr_en;
        t_off       wr_off;
        logic       wr_new;
        logic       hit;
        logic       n_inc;
        logic       n_dec;
        logic       set_status;
        logic [1:0] status;
        logic       finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       cnt_zero;
        logic       cnt_full;
        logic       idx_zero;
        logic       idx_one;
        logic       last;
        logic       last2;
        logic       lt;
        logic       gt;
        logic       tmatch;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

/* design/sppq_ram.sv */
// ----------------------------------------------------------------------------
// sppq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sppq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* design/sppq_dp.sv */
// ----------------------------------------------------------------------------
// sppq_dp
// Datapath: entry and count memories, index, compare flags, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sppq_dp #(
    parameter int SLOTS    = 8,
    parameter int NUM_SEMS = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sppq_pkg::t_in   i_in_data,
    input  wire sppq_pkg::t_cmd  i_cmd,
    input  wire logic            i_out_ready,
    output sppq_pkg::t_sts       o_sts,
    output logic                 o_out_valid,
    output sppq_pkg::t_out       o_out_data
);

    localparam int IW    = $clog2(SLOTS);
    localparam int QW    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int DEPTH = NUM_SEMS * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [1:0]          r_func;
    logic [QW-1:0]       r_q;
    logic [7:0]          r_tid;
    logic [7:0]          r_prio;
    logic [IW-1:0]       r_n;
    logic [IW-1:0]       r_nfin;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       n_idx;
    logic [1:0]          r_status;
    logic [7:0]          r_otask;
    logic [7:0]          r_oprio;
    logic                r_out_valid;
    sppq_pkg::t_out      r_out;
    logic [NUM_SEMS-1:0] r_cnt_vld;

    logic [QW-1:0]       w_q_in;
    logic [IW-1:0]       w_cnt_rdata;
    logic [IW-1:0]       w_cnt;
    sppq_pkg::t_entry    w_rdata;
    sppq_pkg::t_entry    w_wdata;
    logic [AW-1:0]       w_base;
    logic [AW-1:0]       w_raddr;
    logic [AW-1:0]       w_waddr;

    function automatic logic [IW-1:0] f_off(input logic [IW-1:0] idx,
                                            input sppq_pkg::t_off off);
        logic [IW-1:0] res;
        unique case (off)
            sppq_pkg::OFF_PLUS:  res = idx + IW'(1);
            sppq_pkg::OFF_MINUS: res = idx - IW'(1);
            default:             res = idx;
        endcase
        return res;
    endfunction

    // semaphore number folded into range
    always_comb begin
        logic [2:0] v;
        v = {1'b0, i_in_data.sem_id};
        for (int k = 0; k < 3; k++) begin
            if (int'(v) >= NUM_SEMS) begin
                v = v - 3'(NUM_SEMS);
            end
        end
        w_q_in = QW'(v);
    end

    always_comb begin
        unique case (i_cmd.idx_op)
            sppq_pkg::IDX_INC:  n_idx = r_idx + IW'(1);
            sppq_pkg::IDX_DEC:  n_idx = r_idx - IW'(1);
            sppq_pkg::IDX_ZERO: n_idx = '0;
            sppq_pkg::IDX_TAIL: n_idx = w_cnt - IW'(1);
            default:            n_idx = r_idx;
        endcase
    end

    assign w_cnt   = r_cnt_vld[r_q] ? w_cnt_rdata : '0;
    assign w_base  = AW'(r_q) * AW'(SLOTS);
    assign w_raddr = w_base + AW'(f_off(n_idx, i_cmd.rd_off));
    assign w_waddr = w_base + AW'(f_off(r_idx, i_cmd.wr_off));
    assign w_wdata = i_cmd.wr_new ? sppq_pkg::t_entry'({r_tid, r_prio}) : w_rdata;

    sppq_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_SEMS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish),
        .i_waddr (r_q),
        .i_wdata (r_nfin),
        .i_re    (i_cmd.load),
        .i_raddr (w_q_in),
        .o_rdata (w_cnt_rdata)
    );

    sppq_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_func   <= i_in_data.func;
            r_q      <= w_q_in;
            r_tid    <= i_in_data.task_id;
            r_prio   <= i_in_data.priority_req;
            r_status <= sppq_pkg::ST_OK;
            r_otask  <= '0;
            r_oprio  <= '0;
        end
        if (i_cmd.start) begin
            r_n    <= w_cnt;
            r_nfin <= w_cnt;
        end else if (i_cmd.n_inc) begin
            r_nfin <= r_nfin + IW'(1);
        end else if (i_cmd.n_dec) begin
            r_nfin <= r_nfin - IW'(1);
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.hit) begin
            r_otask <= w_rdata.task_id;
            r_oprio <= w_rdata.prio;
        end
        if (i_cmd.finish) begin
            r_out <= '{status: r_status, out_task: r_otask, out_prio: r_oprio,
                       queue_count: 3'(r_nfin)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt_vld   <= '0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid    <= 1'b1;
                r_cnt_vld[r_q] <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.func     = r_func;
        o_sts.cnt_zero = (w_cnt == '0);
        o_sts.cnt_full = (w_cnt == IW'(SLOTS - 1));
        o_sts.idx_zero = (r_idx == '0);
        o_sts.idx_one  = (r_idx == IW'(1));
        o_sts.last     = ((IW+1)'(r_idx) + (IW+1)'(1)) >= (IW+1)'(r_n);
        o_sts.last2    = ((IW+1)'(r_idx) + (IW+1)'(2)) >= (IW+1)'(r_n);
        o_sts.lt       = (w_rdata.prio < r_prio);
        o_sts.gt       = (w_rdata.prio > r_prio);
        o_sts.tmatch   = (w_rdata.task_id == r_tid);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* design/sppq_ctrl.sv */
// ----------------------------------------------------------------------------
// sppq_ctrl
// Controller: walks the addressed queue one entry per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sppq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire sppq_pkg::t_sts i_sts,
    output logic                o_in_ready,
    output sppq_pkg::t_cmd      o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CNT   = 10'b0000000010,
        S_PUSH  = 10'b0000000100,
        S_HEAD  = 10'b0000001000,
        S_FIND  = 10'b0000010000,
        S_SHL   = 10'b0000100000,
        S_UP    = 10'b0001000000,
        S_DOWN  = 10'b0010000000,
        S_PLACE = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.idx_op = sppq_pkg::IDX_HOLD;
        o_cmd.rd_off = sppq_pkg::OFF_ZERO;
        o_cmd.wr_off = sppq_pkg::OFF_ZERO;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CNT;
                end
            end
            S_CNT: begin
                o_cmd.start = 1'b1;
                if (i_sts.func == sppq_pkg::FUNC_PUSH) begin
                    if (i_sts.cnt_full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = sppq_pkg::ST_FULL;
                        n_state          = S_FIN;
                    end else if (i_sts.cnt_zero) begin
                        o_cmd.idx_op = sppq_pkg::IDX_ZERO;
                        n_state      = S_HEAD;
                    end else begin
                        o_cmd.idx_op = sppq_pkg::IDX_TAIL;
                        o_cmd.rd_en  = 1'b1;
                        n_state      = S_PUSH;
                    end
                end else if (i_sts.cnt_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = (i_sts.func == sppq_pkg::FUNC_POP) ?
                                       sppq_pkg::ST_EMPTY : sppq_pkg::ST_NOTFOUND;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.idx_op = sppq_pkg::IDX_ZERO;
                    o_cmd.rd_en  = 1'b1;
                    n_state      = S_FIND;
                end
            end
            S_PUSH: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_off = sppq_pkg::OFF_PLUS;
                if (i_sts.lt) begin
                    // lower priority entry moves one slot toward the tail
                    if (i_sts.idx_zero) begin
                        n_state = S_HEAD;
                    end else begin
                        o_cmd.idx_op = sppq_pkg::IDX_DEC;
                        o_cmd.rd_en  = 1'b1;
                    end
                end else begin
                    o_cmd.wr_new = 1'b1;
                    o_cmd.n_inc  = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_HEAD: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_new = 1'b1;
                o_cmd.n_inc  = 1'b1;
                n_state      = S_FIN;
            end
            S_FIND: begin
                if (i_sts.func == sppq_pkg::FUNC_POP || i_sts.tmatch) begin
                    if (i_sts.func == sppq_pkg::FUNC_CHG) begin
                        if (!i_sts.idx_zero) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_off = sppq_pkg::OFF_MINUS;
                            n_state      = S_UP;
                        end else if (!i_sts.last) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_off = sppq_pkg::OFF_PLUS;
                            n_state      = S_DOWN;
                        end else begin
                            n_state = S_PLACE;
                        end
                    end else begin
                        o_cmd.hit   = 1'b1;
                        o_cmd.n_dec = 1'b1;
                        if (i_sts.last) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.idx_op = sppq_pkg::IDX_INC;
                            o_cmd.rd_en  = 1'b1;
                            n_state      = S_SHL;
                        end
                    end
                end else if (i_sts.last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = sppq_pkg::ST_NOTFOUND;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.idx_op = sppq_pkg::IDX_INC;
                    o_cmd.rd_en  = 1'b1;
                end
            end
            S_SHL: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_off = sppq_pkg::OFF_MINUS;
                if (i_sts.last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.idx_op = sppq_pkg::IDX_INC;
                    o_cmd.rd_en  = 1'b1;
                end
            end
            S_UP: begin
                if (i_sts.lt) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.idx_op = sppq_pkg::IDX_DEC;
                    if (i_sts.idx_one) begin
                        n_state = S_PLACE;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_off = sppq_pkg::OFF_MINUS;
                    end
                end else if (!i_sts.last) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_off = sppq_pkg::OFF_PLUS;
                    n_state      = S_DOWN;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DOWN: begin
                if (i_sts.gt) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.idx_op = sppq_pkg::IDX_INC;
                    if (i_sts.last2) begin
                        n_state = S_PLACE;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_off = sppq_pkg::OFF_PLUS;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_new = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/semaphore_priority_wait_queue_unit.sv */
// ----------------------------------------------------------------------------
// semaphore_priority_wait_queue_unit
// Per-semaphore wait queues of task ids sorted by descending priority.
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready / i_in_data) carries one transaction
//   per operation: push, pop highest, change priority or remove, on the queue
//   of sem_id (folded into NUM_SEMS)
//   output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
//   transaction per input: status, popped or removed task and priority, and
//   the queue's entry count afterwards
//   one operation at a time; each walks the queue in a one-read, one-write entry
//   memory, one entry per cycle; what each operation walks:
//     push into a full queue, or other operations on an empty queue: no walk
//     push: entries moved toward the tail
//     pop, remove, or change of an absent task: every entry in the queue
//     change: entries up to the match, then re-sort steps (entries moved plus
//     at most two compares that end the move)
//   once the result is registered, the next transaction can be accepted
//   the result sits in an output register; the next transaction is taken
//   while it waits, and only a second finished result waits for the receiver
//   reset clears the controller, the output valid flag and the per-queue count
//   valid bits, so every queue reads empty at once; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module semaphore_priority_wait_queue_unit #(
    parameter int SLOTS    = 8,
    parameter int NUM_SEMS = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire sppq_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output sppq_pkg::t_out      o_out_data
);

    // command and status between sequencer and datapath
    sppq_pkg::t_cmd w_cmd;
    sppq_pkg::t_sts w_sts;

    // sequencer: dispatches on the operation and steps through the queue
    sppq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // datapath: entry memory, count memory, compares and result register
    sppq_dp #(
        .SLOTS    (SLOTS),
        .NUM_SEMS (NUM_SEMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* sim/semaphore_priority_wait_queue_unit_test.sv */
// ----------------------------------------------------------------------------
// semaphore_priority_wait_queue_unit_test
// Drives push, pop, change and remove operations into the wait queue unit and
// checks every result against a behavioral model of the sorted queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module semaphore_priority_wait_queue_unit_test;

    localparam int SLOTS    = 8;
    localparam int NUM_SEMS = 4;
    localparam int CAP      = SLOTS - 1;
    localparam int WATCHDOG_LIMIT = 2000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    sppq_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    sppq_pkg::t_out o_out_data;

    semaphore_priority_wait_queue_unit #(
        .SLOTS(SLOTS),
        .NUM_SEMS(NUM_SEMS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    // model of the queues: head first, sorted by descending priority
    logic [7:0] wq_task [NUM_SEMS][SLOTS];
    logic [7:0] wq_prio [NUM_SEMS][SLOTS];
    int         wq_count [NUM_SEMS];

    sppq_pkg::t_out pending_results[$];
    int   error_count;
    int   idle_cycles;
    bit   sender_idles;
    bit   receiver_idles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one operation to the model and return the result it gives
    function automatic sppq_pkg::t_out apply_queue_op(sppq_pkg::t_in op);
        sppq_pkg::t_out r;
        int q;
        int n;
        int ins;
        int pos;
        logic [7:0] t;
        logic [7:0] p;
        q = op.sem_id % NUM_SEMS;
        n = wq_count[q];
        r = '0;
        case (op.func)
            sppq_pkg::FUNC_PUSH: begin
                if (n >= CAP) begin
                    r.status = sppq_pkg::ST_FULL;
                end else begin
                    ins = 0;
                    while (ins < n && wq_prio[q][ins] >= op.priority_req) ins++;
                    for (int i = n; i > ins; i--) begin
                        wq_task[q][i] = wq_task[q][i-1];
                        wq_prio[q][i] = wq_prio[q][i-1];
                    end
                    wq_task[q][ins] = op.task_id;
                    wq_prio[q][ins] = op.priority_req;
                    n++;
                end
            end
            sppq_pkg::FUNC_POP: begin
                if (n == 0) begin
                    r.status = sppq_pkg::ST_EMPTY;
                end else begin
                    r.out_task = wq_task[q][0];
                    r.out_prio = wq_prio[q][0];
                    for (int i = 0; i + 1 < n; i++) begin
                        wq_task[q][i] = wq_task[q][i+1];
                        wq_prio[q][i] = wq_prio[q][i+1];
                    end
                    n--;
                end
            end
            default: begin
                pos = -1;
                for (int i = 0; i < n; i++)
                    if (pos < 0 && wq_task[q][i] == op.task_id) pos = i;
                if (pos < 0) begin
                    r.status = sppq_pkg::ST_NOTFOUND;
                end else if (op.func == sppq_pkg::FUNC_CHG) begin
                    wq_prio[q][pos] = op.priority_req;
                    // stable bubble sort, descending
                    for (int i = 0; i + 1 < n; i++)
                        for (int j = 0; j + 1 < n - i; j++)
                            if (wq_prio[q][j] < wq_prio[q][j+1]) begin
                                t = wq_task[q][j];
                                p = wq_prio[q][j];
                                wq_task[q][j] = wq_task[q][j+1];
                                wq_prio[q][j] = wq_prio[q][j+1];
                                wq_task[q][j+1] = t;
                                wq_prio[q][j+1] = p;
                            end
                end else begin
                    r.out_task = wq_task[q][pos];
                    r.out_prio = wq_prio[q][pos];
                    for (int i = pos; i + 1 < n; i++) begin
                        wq_task[q][i] = wq_task[q][i+1];
                        wq_prio[q][i] = wq_prio[q][i+1];
                    end
                    n--;
                end
            end
        endcase
        wq_count[q] = n;
        r.queue_count = n[2:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // send one transaction, after an optional random gap
    task automatic send_op(logic [1:0] func, logic [1:0] sem, logic [7:0] tid,
                           logic [7:0] prio);
        sppq_pkg::t_in op;
        int gap;
        op.func = func;
        op.sem_id = sem;
        op.task_id = tid;
        op.priority_req = prio;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(apply_queue_op(op));
        @(negedge i_clk);
    endtask

    // receiver side: random stall bursts on ready
    initial begin
        int burst;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (receiver_idles && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                burst = $urandom_range(1, 17);
                repeat (burst) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        sppq_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.out_task !== want.out_task)
                    report_mismatch("out_task", o_out_data.out_task, want.out_task);
                if (o_out_data.out_prio !== want.out_prio)
                    report_mismatch("out_prio", o_out_data.out_prio, want.out_prio);
                if (o_out_data.queue_count !== want.queue_count)
                    report_mismatch("queue_count", o_out_data.queue_count,
                                    want.queue_count);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // directed: extremes, every operation, full, empty and absent cases
    task automatic test_directed();
        send_op(sppq_pkg::FUNC_POP, 2'd0, 8'd0, 8'd0);
        send_op(sppq_pkg::FUNC_REM, 2'd0, 8'd5, 8'd0);
        send_op(sppq_pkg::FUNC_CHG, 2'd0, 8'd5, 8'd9);
        for (int i = 0; i < CAP + 1; i++)
            send_op(sppq_pkg::FUNC_PUSH, 2'd3, 8'(i * 36 + 3),
                    (i % 2) ? 8'd255 : 8'd0);
        send_op(sppq_pkg::FUNC_PUSH, 2'd1, 8'hFF, 8'h80);
        send_op(sppq_pkg::FUNC_PUSH, 2'd1, 8'hFF, 8'h80);
        send_op(sppq_pkg::FUNC_CHG, 2'd3, 8'd3, 8'd255);
        send_op(sppq_pkg::FUNC_CHG, 2'd3, 8'd39, 8'd0);
        send_op(sppq_pkg::FUNC_REM, 2'd3, 8'd75, 8'd0);
        send_op(sppq_pkg::FUNC_REM, 2'd1, 8'hFF, 8'd0);
        send_op(sppq_pkg::FUNC_POP, 2'd3, 8'd0, 8'd0);
        send_op(sppq_pkg::FUNC_POP, 2'd1, 8'd0, 8'd0);
        send_op(sppq_pkg::FUNC_POP, 2'd1, 8'd0, 8'd0);
        send_op(sppq_pkg::FUNC_REM, 2'd2, 8'd0, 8'd0);
    endtask

    task automatic test_random(int count);
        logic [1:0] sem;
        logic [7:0] tid;
        int q;
        for (int k = 0; k < count; k++) begin
            sem = 2'($urandom_range(0, 3));
            q = sem % NUM_SEMS;
            // mostly target tasks that are queued, else a small id pool or any id
            if (wq_count[q] > 0 && $urandom_range(0, 3) != 0)
                tid = wq_task[q][$urandom_range(0, wq_count[q] - 1)];
            else if ($urandom_range(0, 1))
                tid = 8'($urandom_range(0, 15));
            else
                tid = 8'($urandom);
            send_op(2'($urandom_range(0, 3)), sem, tid,
                    ($urandom_range(0, 1)) ? 8'($urandom_range(0, 7))
                                           : 8'($urandom));
        end
    endtask

    // sender holds off until every result is back
    task automatic test_drain_pause();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        send_op(sppq_pkg::FUNC_POP, 2'd2, 8'd0, 8'd0);
    endtask

    initial begin
        error_count = 0;
        idle_cycles = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        for (int q = 0; q < NUM_SEMS; q++) wq_count[q] = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(250);
        test_drain_pause();
        test_random(200);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        test_random(100);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
